// ----- design/rational_arithmetic_unit_macros.svh -----
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/rau_pkg.sv -----
// package for the rational arithmetic unit: types, codes and sizes
package rau_pkg;
  localparam int PW = 32;
  localparam int WW = 2 * PW;
  localparam int CW = $clog2(WW + 1);

  typedef enum logic [2:0] {
    K_ADD = 3'd0, K_SUB = 3'd1, K_MUL = 3'd2, K_DIV = 3'd3, K_CMP = 3'd4, K_NRM = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_OVF = 2'd2
  } status_t;

  // shared micro operations of the datapath
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RED_INIT, OP_GCD_STEP, OP_DIV_INIT, OP_DIV_STEP,
    OP_SAVE_A, OP_SAVE_B, OP_MUL1, OP_MUL2, OP_COMBINE, OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_GA, S_DA, S_RB, S_GB, S_DB, S_M1, S_M2, S_CB,
    S_RR, S_GR, S_DR, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
  } rau_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic skip;
  } rau_sts_t;
endpackage

// ----- design/rau_ctrl.sv -----
// sequencer for the rational arithmetic unit
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  rau_sts_t sts,
  output rau_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RA;
      S_RA:   state_nxt = sts.skip ? S_RB : S_GA;
      S_GA:   if (sts.gcd_done) state_nxt = S_DA;
      S_DA:   if (sts.div_done) state_nxt = S_RB;
      S_RB:   state_nxt = sts.skip ? S_M1 : S_GB;
      S_GB:   if (sts.gcd_done) state_nxt = S_DB;
      S_DB:   if (sts.div_done) state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_CB;
      S_CB:   state_nxt = S_RR;
      S_RR:   state_nxt = sts.skip ? S_FIN : S_GR;
      S_GR:   if (sts.gcd_done) state_nxt = S_DR;
      S_DR:   if (sts.div_done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE};
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin busy = 1'b0; if (in_fire) cmd.op = OP_LOAD; end
      S_RA:   cmd.op = sts.skip ? OP_SAVE_A : OP_RED_INIT;
      S_GA:   cmd.op = sts.gcd_done ? OP_DIV_INIT : OP_GCD_STEP;
      S_DA:   cmd.op = sts.div_done ? OP_SAVE_A : OP_DIV_STEP;
      S_RB:   cmd.op = sts.skip ? OP_SAVE_B : OP_RED_INIT;
      S_GB:   cmd.op = sts.gcd_done ? OP_DIV_INIT : OP_GCD_STEP;
      S_DB:   cmd.op = sts.div_done ? OP_SAVE_B : OP_DIV_STEP;
      S_M1:   cmd.op = OP_MUL1;
      S_M2:   cmd.op = OP_MUL2;
      S_CB:   cmd.op = OP_COMBINE;
      S_RR:   cmd.op = sts.skip ? OP_NONE : OP_RED_INIT;
      S_GR:   cmd.op = sts.gcd_done ? OP_DIV_INIT : OP_GCD_STEP;
      S_DR:   cmd.op = sts.div_done ? OP_NONE : OP_DIV_STEP;
      S_FIN:  cmd.op = OP_FINISH;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- design/rau_dp.sv -----
// datapath: operand registers, binary gcd, serial divider, products and result
module rau_dp import rau_pkg::*; (
  input  logic          clk,
  input  rau_cmd_t      cmd,
  input  logic [2:0]    in_kind,
  input  logic [PW-1:0] in_an,
  input  logic [PW-1:0] in_ad,
  input  logic [PW-1:0] in_bn,
  input  logic [PW-1:0] in_bd,
  output rau_sts_t      sts,
  output logic [31:0]   res_num,
  output logic [30:0]   res_den,
  output logic          res_eq,
  output logic [1:0]    res_status
);
  logic [2:0]    kind_r;
  logic [PW-1:0] an_r, ad_r, bn_r, bd_r;
  // canonical operands
  logic          aneg_r, bneg_r, abad_r, bbad_r;
  logic [PW-1:0] amag_r, aden_r, bmag_r, bden_r;
  // fraction under reduction
  logic          rneg_r, rbad_r;
  logic [WW-1:0] rmag_r, rden_r;
  // gcd registers
  logic [WW-1:0] gu_r, gv_r;
  logic [CW-1:0] gk_r;
  // divider: quotients of mag and den by gcd in parallel
  logic [WW-1:0] dq0_r, dq1_r, dr0_r, dr1_r, dd_r;
  logic [CW-1:0] dc_r;
  // products
  logic [WW-1:0] p0_r, p1_r, p2_r;

  logic          okind;
  logic [WW-1:0] lo_bound;

  assign okind = (kind_r <= K_DIV) || (kind_r == K_NRM);
  assign lo_bound = {{(WW-PW+1){1'b0}}, {(PW-1){1'b1}}};

  // skip means the fraction under reduction needs no gcd (zero part)
  always_comb begin
    sts.gcd_done = (gv_r == '0);
    sts.div_done = (dc_r == '0);
    sts.skip = (rden_r == '0) || (rmag_r == '0);
  end

  logic [WW-1:0] gu_s, gv_s, gdiff;
  logic [WW:0]   t0, t1;

  always_comb begin
    gu_s = gu_r;
    gv_s = gv_r;
    if (gu_r > gv_r) begin gu_s = gv_r; gv_s = gu_r; end
    gdiff = gv_s - gu_s;
    t0 = {dr0_r, dq0_r[WW-1]} - {1'b0, dd_r};
    t1 = {dr1_r, dq1_r[WW-1]} - {1'b0, dd_r};
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r <= in_kind;
        an_r <= in_an; ad_r <= in_ad; bn_r <= in_bn; bd_r <= in_bd;
        rneg_r <= (in_an[PW-1] != in_ad[PW-1]);
        rmag_r <= {{(WW-PW){1'b0}}, in_an[PW-1] ? (~in_an + 1'b1) : in_an};
        rden_r <= {{(WW-PW){1'b0}}, in_ad[PW-1] ? (~in_ad + 1'b1) : in_ad};
        rbad_r <= (in_ad == '0);
      end
      OP_RED_INIT: begin
        gu_r <= rmag_r; gv_r <= rden_r; gk_r <= '0;
      end
      OP_GCD_STEP: begin
        if (!gu_r[0] && !gv_r[0]) begin
          gu_r <= gu_r >> 1; gv_r <= gv_r >> 1; gk_r <= gk_r + 1'b1;
        end else if (!gu_r[0]) gu_r <= gu_r >> 1;
        else if (!gv_r[0]) gv_r <= gv_r >> 1;
        else begin gu_r <= gu_s; gv_r <= gdiff; end
      end
      OP_DIV_INIT: begin
        dd_r <= gu_r << gk_r;
        dq0_r <= rmag_r; dq1_r <= rden_r;
        dr0_r <= '0; dr1_r <= '0;
        dc_r <= CW'(WW);
      end
      OP_DIV_STEP: begin
        dc_r <= dc_r - 1'b1;
        if (!t0[WW]) begin dr0_r <= t0[WW-1:0]; dq0_r <= {dq0_r[WW-2:0], 1'b1}; end
        else begin dr0_r <= {dr0_r[WW-2:0], dq0_r[WW-1]}; dq0_r <= {dq0_r[WW-2:0], 1'b0}; end
        if (!t1[WW]) begin dr1_r <= t1[WW-1:0]; dq1_r <= {dq1_r[WW-2:0], 1'b1}; end
        else begin dr1_r <= {dr1_r[WW-2:0], dq1_r[WW-1]}; dq1_r <= {dq1_r[WW-2:0], 1'b0}; end
      end
      OP_SAVE_A: begin
        abad_r <= rbad_r;
        aneg_r <= rbad_r || rmag_r == '0 ? 1'b0 : rneg_r;
        amag_r <= rbad_r || rmag_r == '0 ? '0 : (sts.div_done && dc_r == '0 &&
                  !sts.skip ? dq0_r[PW-1:0] : rmag_r[PW-1:0]);
        aden_r <= rbad_r || rmag_r == '0 ? PW'(1) : (!sts.skip ? dq1_r[PW-1:0] :
                  rden_r[PW-1:0]);
        rmag_r <= {{(WW-PW){1'b0}}, bn_r[PW-1] ? (~bn_r + 1'b1) : bn_r};
        rden_r <= {{(WW-PW){1'b0}}, bd_r[PW-1] ? (~bd_r + 1'b1) : bd_r};
        rneg_r <= bn_r[PW-1] != bd_r[PW-1];
        rbad_r <= (bd_r == '0);
      end
      OP_SAVE_B: begin
        bbad_r <= rbad_r;
        bneg_r <= rbad_r || rmag_r == '0 ? 1'b0 : rneg_r;
        bmag_r <= rbad_r || rmag_r == '0 ? '0 : (!sts.skip ? dq0_r[PW-1:0] :
                  rmag_r[PW-1:0]);
        bden_r <= rbad_r || rmag_r == '0 ? PW'(1) : (!sts.skip ? dq1_r[PW-1:0] :
                  rden_r[PW-1:0]);
      end
      OP_MUL1: begin
        if (kind_r == K_DIV) begin
          p0_r <= WW'(amag_r) * WW'(bden_r); p1_r <= WW'(aden_r) * WW'(bmag_r);
        end else if (kind_r == K_MUL) begin
          p0_r <= WW'(amag_r) * WW'(bmag_r); p1_r <= WW'(aden_r) * WW'(bden_r);
        end else begin
          p0_r <= WW'(amag_r) * WW'(bden_r); p1_r <= WW'(bmag_r) * WW'(aden_r);
        end
      end
      OP_MUL2: p2_r <= WW'(aden_r) * WW'(bden_r);
      OP_COMBINE: begin
        rbad_r <= abad_r || bbad_r || (kind_r == K_DIV && bmag_r == '0);
        if (kind_r == K_NRM || kind_r == K_CMP || kind_r > K_NRM) begin
          rneg_r <= aneg_r; rmag_r <= WW'(amag_r); rden_r <= WW'(aden_r);
          rbad_r <= abad_r;
        end else if (kind_r == K_MUL || kind_r == K_DIV) begin
          rneg_r <= aneg_r != bneg_r; rmag_r <= p0_r; rden_r <= p1_r;
        end else begin
          rden_r <= p2_r;
          if (aneg_r == (bneg_r ^ (kind_r == K_SUB))) begin
            rneg_r <= aneg_r; rmag_r <= p0_r + p1_r;
          end else if (p0_r >= p1_r) begin
            rneg_r <= aneg_r; rmag_r <= p0_r - p1_r;
          end else begin
            rneg_r <= bneg_r ^ (kind_r == K_SUB); rmag_r <= p1_r - p0_r;
          end
        end
      end
      OP_FINISH: begin
        res_eq <= 1'b0; res_num <= '0; res_den <= 31'd1; res_status <= ST_OK;
        if (kind_r == K_CMP) begin
          if (abad_r || bbad_r) res_status <= ST_ZERO_DEN;
          else res_eq <= aneg_r == bneg_r && amag_r == bmag_r && aden_r == bden_r;
        end else if (okind) begin
          if (rbad_r) res_status <= ST_ZERO_DEN;
          else if (rmag_r == '0) ;
          else if (dq0_r > (rneg_r ? lo_bound + 1'b1 : lo_bound) ||
                   dq1_r > lo_bound) res_status <= ST_OVF;
          else begin
            res_num <= 32'(rneg_r ? (~dq0_r + 1'b1) : dq0_r);
            res_den <= 31'(dq1_r);
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- design/rational_arithmetic_unit.sv -----
// top level of the rational arithmetic unit
// Usage:
//   in_tdata carries two fractions A and B and in_tuser the kind of one item. One beat in
//   gives exactly one beat out with a reduced fraction, an equality flag for
//   compare and a status (0 ok, 1 zero denominator, 2 overflow).
//   Items are processed one at a time: in_tready is high only when idle.
//   Each operand and the final result pass through a binary gcd loop and a
//   64-step restoring divider that divides numerator and denominator by the
//   gcd together; the product steps M1 and M2 and the combine step sit between them.
//   Latency depends on the operands and is set by the gcd and divider loops;
//   the next beat is taken in the cycle after the result leaves.
//   The result is held in a register with out_tvalid high until the receiver
//   takes it; a stalled receiver holds the block, and no new beat is taken
//   until then.
//   A synchronous active-low reset returns the sequencer to idle and drops
//   out_tvalid; no memory needs clearing.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_numerator, a_denominator, b_numerator, b_denominator
  input  logic [127:0] in_tdata,
  // kind
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_numerator, result_denominator, is_equal
  output logic [63:0]  out_tdata,
  // status
  output logic [1:0]   out_tuser
);
  `include "rational_arithmetic_unit_macros.svh"

  rau_cmd_t cmd;
  rau_sts_t sts;
  logic busy, in_fire, out_fire;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic res_eq;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_tdata = {res_eq, res_den, res_num};

  rau_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd, .busy, .out_valid(out_tvalid)
  );

  rau_dp u_dp (
    .clk, .cmd, .in_kind(in_tuser),
    .in_an(in_tdata[31:0]), .in_ad(in_tdata[63:32]),
    .in_bn(in_tdata[95:64]), .in_bd(in_tdata[127:96]),
    .sts, .res_num, .res_den, .res_eq, .res_status(out_tuser)
  );

  `RAU_ASSERT_IMP(a_no_take_while_out, out_tvalid, !in_tready)
  `RAU_ASSERT_NEXT(a_drop_after_take, out_fire, !out_tvalid)
  `RAU_ASSERT_IMP(a_den_positive, out_tvalid, out_tdata[62:32] != 31'd0)
endmodule

// ----- dv/rational_arithmetic_unit_checker.sv -----
// checker for the rational arithmetic unit: predicts each result and compares
module rational_arithmetic_unit_checker import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           outstanding,
  output int           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit        neg;
    bit [63:0] mag;
    bit [63:0] den;
    bit        bad;
  } frac_s;

  typedef struct {
    bit [31:0] num;
    bit [30:0] den;
    bit        eq;
    bit [1:0]  st;
  } answer_s;

  localparam bit [63:0] HALF = 64'd1 << (PW - 1);

  answer_s answers_due[$];

  function automatic bit [63:0] part_mag(bit [31:0] v, output bit neg);
    neg = v[31];
    return neg ? {32'd0, -v} : {32'd0, v};
  endfunction

  function automatic bit [63:0] gcd64(bit [63:0] a, bit [63:0] b);
    bit [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_s reduce_frac(bit neg, bit [63:0] mag, bit [63:0] den);
    frac_s f;
    bit [63:0] g;
    f = '{neg: 0, mag: 0, den: 1, bad: 0};
    if (den == 0) begin
      f.bad = 1;
      return f;
    end
    if (mag == 0) return f;
    g = gcd64(mag, den);
    f.neg = neg;
    f.mag = mag / g;
    f.den = den / g;
    return f;
  endfunction

  function automatic frac_s canon_frac(bit [31:0] n, bit [31:0] d);
    bit nn, dn;
    bit [63:0] nm, dm;
    nm = part_mag(n, nn);
    dm = part_mag(d, dn);
    return reduce_frac(nn != dn, nm, dm);
  endfunction

  function automatic frac_s add_frac(frac_s a, frac_s b, bit flip);
    bit [63:0] x, y, den;
    bit yn;
    x = a.mag * b.den;
    y = b.mag * a.den;
    yn = b.neg != flip;
    den = a.den * b.den;
    if (a.neg == yn) return reduce_frac(a.neg, x + y, den);
    if (x >= y) return reduce_frac(a.neg, x - y, den);
    return reduce_frac(yn, y - x, den);
  endfunction

  function automatic answer_s predict_answer(bit [2:0] kind, bit [127:0] d);
    frac_s a, b, r;
    answer_s ans;
    bit [63:0] lim;
    a = canon_frac(d[31:0], d[63:32]);
    b = canon_frac(d[95:64], d[127:96]);
    r = '{neg: 0, mag: 0, den: 1, bad: 0};
    ans = '{num: 0, den: 1, eq: 0, st: ST_OK};
    case (kind)
      K_ADD, K_SUB: begin
        r = (a.bad || b.bad) ? a : add_frac(a, b, kind == K_SUB);
        if (b.bad) r.bad = 1;
      end
      K_MUL: begin
        if (a.bad || b.bad) r.bad = 1;
        else r = reduce_frac(a.neg != b.neg, a.mag * b.mag, a.den * b.den);
      end
      K_DIV: begin
        if (a.bad || b.bad) r.bad = 1;
        else r = reduce_frac(a.neg != b.neg, a.mag * b.den, a.den * b.mag);
      end
      K_CMP: begin
        if (a.bad || b.bad) ans.st = ST_ZERO_DEN;
        else ans.eq = (a.neg == b.neg && a.mag == b.mag && a.den == b.den);
      end
      K_NRM: r = a;
      default: ;
    endcase
    if (kind <= K_DIV || kind == K_NRM) begin
      if (r.bad) begin
        ans.st = ST_ZERO_DEN;
      end else begin
        lim = r.neg ? HALF : HALF - 1;
        if (r.mag > lim || r.den > HALF - 1 || r.den == 0) begin
          ans.st = ST_OVF;
        end else begin
          ans.num = r.neg ? -r.mag[31:0] : r.mag[31:0];
          ans.den = r.den[30:0];
        end
      end
    end
    return ans;
  endfunction

  initial begin
    fail_count = 0;
    outstanding = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    answer_s want;
    if (rst_n) begin
      if (in_tvalid && in_tready) answers_due.push_back(predict_answer(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          $error("result beat with nothing expected: %h %h", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (out_tdata[31:0] !== want.num) begin
            $error("result_numerator expected %h actual %h", want.num, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[62:32] !== want.den) begin
            $error("result_denominator expected %h actual %h", want.den, out_tdata[62:32]);
            fail_count++;
          end
          if (out_tdata[63] !== want.eq) begin
            $error("is_equal expected %b actual %b", want.eq, out_tdata[63]);
            fail_count++;
          end
          if (out_tuser !== want.st) begin
            $error("status expected %0d actual %0d", want.st, out_tuser);
            fail_count++;
          end
        end
      end
      outstanding <= answers_due.size();
    end
  end
endmodule

// ----- dv/rational_arithmetic_unit_tb.sv -----
// testbench top for the rational arithmetic unit: stimulus and verdict
module rational_arithmetic_unit_tb;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 1500;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count, outstanding, results_seen;
  int           send_idle_pct = 31;
  int           recv_idle_pct = 60;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           cycles = 0;
  int           items_sent = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  rational_arithmetic_unit DUT (.*);

  rational_arithmetic_unit_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rational_arithmetic_unit_tb failed");
      $finish;
    end
  end

  // receiver: random stalls plus long hold-offs on request
  initial forever begin
    @(negedge clk);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 0;
      hold_left--;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(bit [2:0] kind, bit [31:0] an, bit [31:0] ad,
                           bit [31:0] bn, bit [31:0] bd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {bd, bn, ad, an};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic bit [31:0] pick_part(bit is_den);
    int sel;
    int span;
    sel = $urandom_range(11);
    span = 1 << $urandom_range(16);
    case (sel)
      0: return is_den ? 32'd1 : 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return 32'd1;
      5, 6, 7: return ($urandom_range(1) ? -1 : 1) * ($urandom_range(span - 1) + 1);
      8: return 32'd12 * $urandom_range(50) + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    bit [2:0] kind;
    bit [31:0] an, ad, bn, bd;
    kind = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    an = pick_part(0);
    ad = pick_part(1);
    bn = pick_part(0);
    bd = pick_part(1);
    if ($urandom_range(19) == 0) ad = 0;
    if ($urandom_range(19) == 0) bd = 0;
    if (kind == K_CMP && $urandom_range(2) == 0) begin
      bn = an * 3;
      bd = ad * 3;
    end
    if (kind == K_DIV && $urandom_range(19) == 0) bn = 0;
    send_beat(kind, an, ad, bn, bd);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_beat(K_ADD, 1, 2, 1, 3);
    send_beat(K_SUB, 1, 2, 1, 2);
    send_beat(K_MUL, -2, 3, 3, -4);
    send_beat(K_DIV, 3, 4, -9, 8);
    send_beat(K_CMP, 2, 4, -1, -2);
    send_beat(K_CMP, 2, 4, 1, 3);
    send_beat(K_NRM, -6, -4, 0, 0);
    send_beat(K_NRM, 0, 7, 0, 0);
    send_beat(K_ADD, 5, 0, 1, 1);
    send_beat(K_MUL, 1, 1, 5, 0);
    send_beat(K_DIV, 1, 2, 0, 3);
    send_beat(K_CMP, 1, 0, 1, 1);
    send_beat(K_ADD, 32'h7fff_ffff, 1, 1, 1);
    send_beat(K_SUB, 32'h8000_0000, 1, 1, 1);
    send_beat(K_NRM, 32'h8000_0000, 1, 0, 1);
    send_beat(K_NRM, 32'h8000_0000, 32'hffff_ffff, 0, 1);
    send_beat(K_NRM, 1, 32'h8000_0000, 0, 1);
    send_beat(K_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(K_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_beat(3'd6, 3, 4, 5, 6);
    send_beat(3'd7, 32'hffff_ffff, 0, 32'hffff_ffff, 0);
    send_beat(K_MUL, 0, 5, 7, 0);

    for (int i = 0; i < 280; i++) begin
      if (i == 140) hold_req++;
      send_random();
    end

    send_idle_pct = 60;
    recv_idle_pct = 31;
    for (int i = 0; i < 280; i++) begin
      if (i == 140) begin
        @(negedge clk);
        in_tvalid <= 0;
        wait (outstanding == 0);
      end
      send_random();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 290; i++) send_random();
    @(negedge clk);
    in_tvalid <= 0;

    wait (outstanding == 0);
    repeat (700) @(posedge clk);
    $display("sent %0d items over all operations, checked %0d results", items_sent,
             results_seen);
    $display("covered stalls on both sides, a long receiver hold-off and a drained pause");
    if (fail_count == 0 && outstanding == 0) begin
      $display("rational_arithmetic_unit_tb passed");
    end else begin
      $display("rational_arithmetic_unit_tb failed");
    end
    $finish;
  end
endmodule
